FILE: hw/rtl/chirp_frame_modulator_assert.svh
// Assertion macros for the chirp frame modulator checkers.
// Used by the bound checker; needs nothing else.
`ifndef CHIRP_FRAME_MODULATOR_ASSERT_SVH
`define CHIRP_FRAME_MODULATOR_ASSERT_SVH

// same-cycle implication
`define CFM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chirp frame modulator check failed");

// next-cycle implication
`define CFM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chirp frame modulator check failed");

`endif

FILE: hw/rtl/cfm_pkg.sv
// Shared types, constants and the arctangent table of the chirp frame modulator.
// No dependencies.
package cfm_pkg;

   localparam int CFM_PAYLOAD_DEPTH = 256;
   localparam int CFM_PHASE_BITS    = 32;
   localparam int CFM_SAMPLE_BITS   = 16;

   localparam int CFM_SYMBOL_BITS = 12;
   localparam int CFM_COUNT_BITS  = 16;
   localparam int CFM_ANGLE_BITS  = 32;
   localparam int CFM_CSR_WIDTH   = 16;

   // register indexes
   localparam logic [1:0] CSR_SPREADING_FACTOR = 2'd0;
   localparam logic [1:0] CSR_OVERSAMPLE_LOG2  = 2'd1;
   localparam logic [1:0] CSR_SYNC_WORD        = 2'd2;
   localparam logic [1:0] CSR_PREAMBLE_COUNT   = 2'd3;

   localparam logic [3:0]  RST_SPREADING_FACTOR = 4'd7;
   localparam logic [1:0]  RST_OVERSAMPLE_LOG2  = 2'd0;
   localparam logic [7:0]  RST_SYNC_WORD        = 8'd18;
   localparam logic [15:0] RST_PREAMBLE_COUNT   = 16'd8;

   localparam logic [3:0] CFM_SF_MIN = 4'd7;
   localparam logic [3:0] CFM_SF_MAX = 4'd12;

   // frame segments
   localparam logic [2:0] CFM_SEG_IDLE = 3'd0;
   localparam logic [2:0] CFM_SEG_PRE  = 3'd1;
   localparam logic [2:0] CFM_SEG_SYNC = 3'd2;
   localparam logic [2:0] CFM_SEG_SFD  = 3'd3;
   localparam logic [2:0] CFM_SEG_PAY  = 3'd4;

   localparam int CFM_SYNC_BIN_SHIFT = 3;   // nibble times 8
   localparam logic [16:0] CFM_SYNC_CHIRPS = 17'd2;
   localparam logic [16:0] CFM_SFD_CHIRPS  = 17'd3;   // two full plus a quarter
   localparam logic [15:0] CFM_SFD_QUARTER_SYM = 16'd2;

   localparam int      CFM_CORDIC_STEPS = 20;
   localparam longint  CFM_GAIN_Q       = 64'sd652032874;
   localparam int      CFM_GAIN_SHIFT   = 16;
   localparam int      CFM_FRAC_SHIFT   = 14;
   localparam int      CFM_ROUND_BIAS   = 8192;

   typedef struct packed {
      logic [3:0]  spreading_factor;
      logic [1:0]  oversample_log2;
      logic [7:0]  sync_word;
      logic [15:0] preamble_count;
   } cfm_cfg_type;

   typedef struct packed {
      logic [1:0] segment;
      logic       frame_last;
   } cfm_tag_type;

   // arctangent of 2^-step, 2^32 = one turn
   function automatic logic signed [31:0] cfm_atan(input int unsigned step);
      logic signed [31:0] a;
      case (step)
         0:  a = 32'sd536870912;
         1:  a = 32'sd316933406;
         2:  a = 32'sd167458907;
         3:  a = 32'sd85004756;
         4:  a = 32'sd42667331;
         5:  a = 32'sd21354465;
         6:  a = 32'sd10679838;
         7:  a = 32'sd5340245;
         8:  a = 32'sd2670163;
         9:  a = 32'sd1335087;
         10: a = 32'sd667544;
         11: a = 32'sd333772;
         12: a = 32'sd166886;
         13: a = 32'sd83443;
         14: a = 32'sd41722;
         15: a = 32'sd20861;
         16: a = 32'sd10430;
         17: a = 32'sd5215;
         18: a = 32'sd2608;
         19: a = 32'sd1304;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

endpackage

FILE: hw/rtl/cfm_if.sv
// Stream channel interfaces of the chirp frame modulator (request and response).
// Depends on cfm_pkg.
interface cfm_req_if;
   import cfm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [CFM_SYMBOL_BITS-1:0] symbol_value;

   modport source (output valid, kind, symbol_value, input ready);
   modport sink   (input valid, kind, symbol_value, output ready);
endinterface

interface cfm_rsp_if #(
   parameter int SAMPLE_BITS = cfm_pkg::CFM_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] in_phase;
   logic signed [SAMPLE_BITS-1:0] quadrature;
   logic [1:0]                    segment;
   logic                          frame_last;

   modport source (output valid, in_phase, quadrature, segment, frame_last, input ready);
   modport sink   (input valid, in_phase, quadrature, segment, frame_last, output ready);
endinterface

FILE: hw/rtl/cfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/cfm_seq.sv
// Frame sequencer: payload store, segment/symbol/sample counters, phase accumulator.
// Depends on cfm_pkg and cfm_ram. Gives the angle and tag of each ticked sample.
module cfm_seq #(
   parameter int PAYLOAD_DEPTH = cfm_pkg::CFM_PAYLOAD_DEPTH,
   parameter int PHASE_BITS    = cfm_pkg::CFM_PHASE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfm_pkg::cfm_cfg_type                 cfg,
   input  logic                                 item_fire,
   input  logic                                 item_kind,
   input  logic [cfm_pkg::CFM_SYMBOL_BITS-1:0]  item_symbol,
   output logic [cfm_pkg::CFM_ANGLE_BITS-1:0]   angle,
   output cfm_pkg::cfm_tag_type                 tag
);
   import cfm_pkg::*;

   localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int CNT_W  = $clog2(PAYLOAD_DEPTH + 1);
   localparam int SH_W   = $clog2(PHASE_BITS + 1);

   logic [PHASE_BITS-1:0]     phase_ff, phase_in;
   logic [2:0]                seg_ff, seg_in;
   logic [CFM_COUNT_BITS-1:0] sym_ff, sym_in;
   logic [CFM_COUNT_BITS-1:0] samp_ff, samp_in;
   logic [CNT_W-1:0]          pcount_ff, pcount_in;

   logic                       is_tick, is_load, store_wr;
   logic [3:0]                 sf_eff;
   logic [4:0]                 nl_log;
   logic [15:0]                nl, nl_mask, len;
   logic [SH_W-1:0]            sh;
   logic                       starting;
   logic [2:0]                 seg_cur;
   logic [PHASE_BITS-1:0]      phase_cur, inc;
   logic [CFM_COUNT_BITS-1:0]  sym_cur, samp_cur;
   logic [CFM_SYMBOL_BITS-1:0] bin, store_data;
   logic [15:0]                bin_os, k_raw, k;
   logic signed [16:0]         diff;
   logic [16:0]                samp_inc, sym_work;
   logic                       last;

   assign is_tick  = item_fire && item_kind;
   assign is_load  = item_fire && !item_kind;
   assign store_wr = is_load && (seg_ff == CFM_SEG_IDLE)
                     && (pcount_ff < CNT_W'(PAYLOAD_DEPTH));

   always_comb begin
      if (cfg.spreading_factor < CFM_SF_MIN) begin
         sf_eff = CFM_SF_MIN;
      end else if (cfg.spreading_factor > CFM_SF_MAX) begin
         sf_eff = CFM_SF_MAX;
      end else begin
         sf_eff = cfg.spreading_factor;
      end
   end

   assign nl_log  = 5'(sf_eff) + 5'(cfg.oversample_log2);
   assign nl      = 16'(1) << nl_log;
   assign nl_mask = nl - 16'd1;
   assign sh      = SH_W'(PHASE_BITS) - SH_W'(sf_eff) - SH_W'({cfg.oversample_log2, 1'b0});

   // an idle block starts a fresh frame on the tick
   assign starting  = (seg_ff == CFM_SEG_IDLE);
   assign seg_cur   = starting ? ((cfg.preamble_count != 16'd0) ? CFM_SEG_PRE : CFM_SEG_SYNC)
                               : seg_ff;
   assign phase_cur = starting ? '0 : phase_ff;
   assign sym_cur   = starting ? '0 : sym_ff;
   assign samp_cur  = starting ? '0 : samp_ff;

   always_comb begin
      case (seg_cur)
         CFM_SEG_SYNC: begin
            if (sym_cur == '0) begin
               bin = CFM_SYMBOL_BITS'(cfg.sync_word[7:4]) << CFM_SYNC_BIN_SHIFT;
            end else begin
               bin = CFM_SYMBOL_BITS'(cfg.sync_word[3:0]) << CFM_SYNC_BIN_SHIFT;
            end
         end
         CFM_SEG_PAY: bin = store_data;
         default:     bin = '0;
      endcase
   end

   assign bin_os = 16'(bin) << cfg.oversample_log2;
   assign k_raw  = (seg_cur == CFM_SEG_SFD) ? (bin_os - samp_cur) : (bin_os + samp_cur);
   assign k      = k_raw & nl_mask;
   assign diff   = $signed({1'b0, k}) - $signed({1'b0, nl >> 1});
   assign inc    = {{(PHASE_BITS-17){diff[16]}}, diff} << sh;

   assign len = ((seg_cur == CFM_SEG_SFD) && (sym_cur == CFM_SFD_QUARTER_SYM)) ? (nl >> 2) : nl;
   assign samp_inc = 17'(samp_cur) + 17'd1;

   always_comb begin
      seg_in    = seg_ff;
      sym_in    = sym_ff;
      samp_in   = samp_ff;
      phase_in  = phase_ff;
      pcount_in = pcount_ff;
      sym_work  = 17'(sym_cur);
      last      = 1'b0;
      if (is_tick) begin
         phase_in = phase_cur + inc;
         seg_in   = seg_cur;
         samp_in  = samp_inc[CFM_COUNT_BITS-1:0];
         if (samp_inc >= 17'(len)) begin
            samp_in  = '0;
            sym_work = 17'(sym_cur) + 17'd1;
            if ((seg_cur == CFM_SEG_PRE) && (sym_work >= 17'(cfg.preamble_count))) begin
               seg_in   = CFM_SEG_SYNC;
               sym_work = '0;
            end else if ((seg_cur == CFM_SEG_SYNC) && (sym_work >= CFM_SYNC_CHIRPS)) begin
               seg_in   = CFM_SEG_SFD;
               sym_work = '0;
            end else if ((seg_cur == CFM_SEG_SFD) && (sym_work >= CFM_SFD_CHIRPS)) begin
               seg_in   = CFM_SEG_PAY;
               sym_work = '0;
            end
            if ((seg_in == CFM_SEG_PAY) && (sym_work >= 17'(pcount_ff))) begin
               seg_in    = CFM_SEG_IDLE;
               sym_work  = '0;
               pcount_in = '0;
               last      = 1'b1;
            end
         end
         sym_in = sym_work[CFM_COUNT_BITS-1:0];
      end else if (store_wr) begin
         pcount_in = pcount_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         seg_ff    <= CFM_SEG_IDLE;
         sym_ff    <= '0;
         samp_ff   <= '0;
         pcount_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         seg_ff    <= seg_in;
         sym_ff    <= sym_in;
         samp_ff   <= samp_in;
         pcount_ff <= pcount_in;
      end
   end

   // read address follows the next symbol index, so data matches sym_ff
   cfm_ram #(
      .WIDTH (CFM_SYMBOL_BITS),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (pcount_ff[ADDR_W-1:0]),
      .wr_data (item_symbol),
      .rd_addr (sym_in[ADDR_W-1:0]),
      .rd_data (store_data)
   );

   generate
      if (PHASE_BITS >= CFM_ANGLE_BITS) begin : g_angle_top
         assign angle = phase_cur[PHASE_BITS-1 -: CFM_ANGLE_BITS];
      end else begin : g_angle_pad
         assign angle = {phase_cur, {(CFM_ANGLE_BITS-PHASE_BITS){1'b0}}};
      end
   endgenerate

   assign tag.segment    = 2'(seg_cur - CFM_SEG_PRE);
   assign tag.frame_last = last;
endmodule

FILE: hw/rtl/cfm_cordic.sv
// Pipelined CORDIC rotator with rounding, saturation and quadrant mapping.
// Depends on cfm_pkg. One rotation step per stage, bubbles collapse under stall.
module cfm_cordic #(
   parameter int SAMPLE_BITS = cfm_pkg::CFM_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [cfm_pkg::CFM_ANGLE_BITS-1:0]  in_angle,
   input  cfm_pkg::cfm_tag_type                in_tag,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [SAMPLE_BITS-1:0]       out_i,
   output logic signed [SAMPLE_BITS-1:0]       out_q,
   output cfm_pkg::cfm_tag_type                out_tag
);
   import cfm_pkg::*;

   localparam int     STEPS = CFM_CORDIC_STEPS;
   localparam int     XW    = SAMPLE_BITS + 16;
   localparam int     RW    = XW - CFM_FRAC_SHIFT;
   localparam longint AMP_L = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint X0_L  = (AMP_L * CFM_GAIN_Q) >>> CFM_GAIN_SHIFT;
   localparam logic signed [XW-1:0] X0        = XW'(X0_L);
   localparam logic signed [XW-1:0] BIAS      = XW'(CFM_ROUND_BIAS);
   localparam logic signed [RW-1:0] AMP_POS   = RW'(AMP_L);
   localparam logic signed [RW-1:0] AMP_NEG   = -RW'(AMP_L);

   logic signed [XW-1:0] x_ff   [0:STEPS];
   logic signed [XW-1:0] y_ff   [0:STEPS];
   logic signed [31:0]   z_ff   [0:STEPS];
   logic [1:0]           quad_ff[0:STEPS];
   cfm_tag_type          tag_ff [0:STEPS];
   logic                 vld_ff [0:STEPS];
   logic                 room   [0:STEPS];
   logic                 room_out;

   logic                 out_vld_ff;
   logic signed [SAMPLE_BITS-1:0] i_ff, q_ff, i_in, q_in;
   cfm_tag_type          otag_ff;

   logic signed [XW-1:0] xr, yr;
   logic signed [RW-1:0] xs, ys, xc, yc;

   assign room_out = !out_vld_ff || out_ready;
   assign room[STEPS] = !vld_ff[STEPS] || room_out;
   assign in_ready = room[0];

   // stage 0: start vector and reduced angle
   always_ff @(posedge clock) begin
      if (room[0]) begin
         x_ff[0]    <= X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({2'b00, in_angle[29:0]});
         quad_ff[0] <= in_angle[31:30];
         tag_ff[0]  <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (room[0]) begin
         vld_ff[0] <= in_valid;
      end
   end

   genvar g;
   generate
      for (g = 1; g <= STEPS; g++) begin : g_step
         if (g < STEPS) begin : g_room
            assign room[g-1] = !vld_ff[g-1] || room[g];
         end else begin : g_room_last
            assign room[g-1] = !vld_ff[g-1] || room[g];
         end

         always_ff @(posedge clock) begin
            if (room[g]) begin
               quad_ff[g] <= quad_ff[g-1];
               tag_ff[g]  <= tag_ff[g-1];
               if (!z_ff[g-1][31]) begin
                  x_ff[g] <= x_ff[g-1] - (y_ff[g-1] >>> (g-1));
                  y_ff[g] <= y_ff[g-1] + (x_ff[g-1] >>> (g-1));
                  z_ff[g] <= z_ff[g-1] - cfm_atan(g-1);
               end else begin
                  x_ff[g] <= x_ff[g-1] + (y_ff[g-1] >>> (g-1));
                  y_ff[g] <= y_ff[g-1] - (x_ff[g-1] >>> (g-1));
                  z_ff[g] <= z_ff[g-1] + cfm_atan(g-1);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[g] <= 1'b0;
            end else if (room[g]) begin
               vld_ff[g] <= vld_ff[g-1];
            end
         end
      end
   endgenerate

   // round to nearest, floor, clamp to the symmetric amplitude
   assign xr = x_ff[STEPS] + BIAS;
   assign yr = y_ff[STEPS] + BIAS;
   assign xs = xr[XW-1:CFM_FRAC_SHIFT];
   assign ys = yr[XW-1:CFM_FRAC_SHIFT];
   assign xc = (xs > AMP_POS) ? AMP_POS : ((xs < AMP_NEG) ? AMP_NEG : xs);
   assign yc = (ys > AMP_POS) ? AMP_POS : ((ys < AMP_NEG) ? AMP_NEG : ys);

   always_comb begin
      case (quad_ff[STEPS])
         2'd0: begin
            i_in = xc[SAMPLE_BITS-1:0];
            q_in = yc[SAMPLE_BITS-1:0];
         end
         2'd1: begin
            i_in = -yc[SAMPLE_BITS-1:0];
            q_in = xc[SAMPLE_BITS-1:0];
         end
         2'd2: begin
            i_in = -xc[SAMPLE_BITS-1:0];
            q_in = -yc[SAMPLE_BITS-1:0];
         end
         default: begin
            i_in = yc[SAMPLE_BITS-1:0];
            q_in = -xc[SAMPLE_BITS-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (room_out) begin
         i_ff    <= i_in;
         q_ff    <= q_in;
         otag_ff <= tag_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (room_out) begin
         out_vld_ff <= vld_ff[STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_i     = i_ff;
   assign out_q     = q_ff;
   assign out_tag   = otag_ff;
endmodule

FILE: hw/rtl/chirp_frame_modulator.sv
// Chirp frame modulator top level: configuration registers, sequencer and rotator.
// Depends on cfm_pkg, cfm_if, cfm_seq, cfm_cordic.
//
// Load payload words (kind 0) while no frame runs, then send tick words (kind 1): each
// tick returns one complex Q1.15 sample, the first tick of an idle block starting a new
// frame (preamble, two sync chirps, two and a quarter down-chirps, payload). One word
// is taken per clock, loads and ticks alike, while the output is not stalled; a tick's
// sample passes the angle register, the one-step-per-stage CORDIC pipeline (20 stages)
// and the output register. Loads give no response. Registers are written with csr_we;
// write them only between frames. The payload store holds PAYLOAD_DEPTH symbols, extra
// loads are dropped, and the store empties at the end of every frame.
module chirp_frame_modulator #(
   parameter int PAYLOAD_DEPTH = cfm_pkg::CFM_PAYLOAD_DEPTH,
   parameter int PHASE_BITS    = cfm_pkg::CFM_PHASE_BITS,
   parameter int SAMPLE_BITS   = cfm_pkg::CFM_SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   cfm_req_if.sink                            req_chan,
   cfm_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [cfm_pkg::CFM_CSR_WIDTH-1:0]  csr_wdata
);
   import cfm_pkg::*;

   cfm_cfg_type cfg_ff, cfg_in;
   logic        item_fire;
   logic        in_ready;
   logic [CFM_ANGLE_BITS-1:0] angle;
   cfm_tag_type tag, out_tag;
   logic signed [SAMPLE_BITS-1:0] out_i, out_q;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPREADING_FACTOR: cfg_in.spreading_factor = csr_wdata[3:0];
            CSR_OVERSAMPLE_LOG2:  cfg_in.oversample_log2  = csr_wdata[1:0];
            CSR_SYNC_WORD:        cfg_in.sync_word        = csr_wdata[7:0];
            CSR_PREAMBLE_COUNT:   cfg_in.preamble_count   = csr_wdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spreading_factor <= RST_SPREADING_FACTOR;
         cfg_ff.oversample_log2  <= RST_OVERSAMPLE_LOG2;
         cfg_ff.sync_word        <= RST_SYNC_WORD;
         cfg_ff.preamble_count   <= RST_PREAMBLE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_chan.ready = in_ready;
   assign item_fire      = req_chan.valid && in_ready;

   cfm_seq #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
      .PHASE_BITS    (PHASE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item_fire   (item_fire),
      .item_kind   (req_chan.kind),
      .item_symbol (req_chan.symbol_value),
      .angle       (angle),
      .tag         (tag)
   );

   cfm_cordic #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_fire && req_chan.kind),
      .in_ready  (in_ready),
      .in_angle  (angle),
      .in_tag    (tag),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_i     (out_i),
      .out_q     (out_q),
      .out_tag   (out_tag)
   );

   assign rsp_chan.in_phase   = out_i;
   assign rsp_chan.quadrature = out_q;
   assign rsp_chan.segment    = out_tag.segment;
   assign rsp_chan.frame_last = out_tag.frame_last;
endmodule

FILE: hw/rtl/cfm_checker.sv
// Port-level checker for the chirp frame modulator, bound to the top level.
// Depends on chirp_frame_modulator_assert.svh and cfm_pkg.
`include "chirp_frame_modulator_assert.svh"

module cfm_checker #(
   parameter int SAMPLE_BITS = cfm_pkg::CFM_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_in_phase,
   input logic signed [SAMPLE_BITS-1:0] rsp_quadrature,
   input logic [1:0]                    rsp_segment,
   input logic                          rsp_frame_last
);
   import cfm_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] HALF_POS =
      SAMPLE_BITS'(((1 << (SAMPLE_BITS - 1)) - 1) / 2);
   localparam logic signed [SAMPLE_BITS-1:0] HALF_NEG = -HALF_POS;

   logic seg_end_ok;
   logic amp_ok;

   // frame ends in the payload, or in the delimiter when no payload was loaded
   assign seg_end_ok = (rsp_segment == 2'd3) || (rsp_segment == 2'd2);
   assign amp_ok = (rsp_in_phase > HALF_POS) || (rsp_in_phase < HALF_NEG)
                   || (rsp_quadrature > HALF_POS) || (rsp_quadrature < HALF_NEG);

   `CFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CFM_ASSERT_IMPL(a_last_segment, clock, reset, rsp_valid && rsp_frame_last, seg_end_ok)
   `CFM_ASSERT_IMPL(a_symmetric, clock, reset, rsp_valid, (rsp_in_phase != MOST_NEG) && (rsp_quadrature != MOST_NEG))
   `CFM_ASSERT_IMPL(a_amplitude, clock, reset, rsp_valid, amp_ok)
endmodule

bind chirp_frame_modulator cfm_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_cfm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_in_phase   (rsp_chan.in_phase),
   .rsp_quadrature (rsp_chan.quadrature),
   .rsp_segment    (rsp_chan.segment),
   .rsp_frame_last (rsp_chan.frame_last)
);

FILE: tb/tb_chirp_frame_modulator.sv
// Testbench for the chirp frame modulator: loads payload words, sends tick words and
// checks every sample word against a predictor of the chirp frame.
// Depends on cfm_pkg, cfm_if and the chirp_frame_modulator RTL.
module tb_chirp_frame_modulator;
   timeunit 1ns;
   timeprecision 1ps;
   import cfm_pkg::*;

   localparam bit WORD_LOAD   = 1'b0;
   localparam bit WORD_TICK   = 1'b1;
   localparam int IDLE_PCT    = 12;
   localparam int DRAIN_WAIT  = 30;    // pipeline is 22 deep; loads give no sample word
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER  = 1200;
   localparam int RANDOM_WORDS = 1050;

   typedef struct packed {
      logic signed [CFM_SAMPLE_BITS-1:0] in_phase;
      logic signed [CFM_SAMPLE_BITS-1:0] quadrature;
      logic [1:0]                        segment;
      logic                              frame_last;
   } sample_type;

   class chirp_scoreboard;
      logic [3:0]  sf_reg;
      logic [1:0]  os_reg;
      logic [7:0]  sync_reg;
      logic [15:0] pre_reg;
      logic [31:0] phase;
      logic [2:0]  seg;
      int unsigned sym_cnt, smp_cnt, pay_cnt;
      logic [CFM_SYMBOL_BITS-1:0] store [CFM_PAYLOAD_DEPTH];
      longint      arc_turns [20];
      sample_type  expected_samples [$];
      int          errors, checked, frames_done;

      function new();
         sf_reg = RST_SPREADING_FACTOR;
         os_reg = RST_OVERSAMPLE_LOG2;
         sync_reg = RST_SYNC_WORD;
         pre_reg = RST_PREAMBLE_COUNT;
         phase = '0;
         seg = CFM_SEG_IDLE;
         sym_cnt = 0;
         smp_cnt = 0;
         pay_cnt = 0;
         errors = 0;
         checked = 0;
         frames_done = 0;
         // arctangent of 2^-i, one turn is 2^32
         arc_turns = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                       10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                       83443, 41722, 20861, 10430, 5215, 2608, 1304};
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      function void write_reg(logic [1:0] index, logic [CFM_CSR_WIDTH-1:0] data);
         case (index)
            CSR_SPREADING_FACTOR: sf_reg = data[3:0];
            CSR_OVERSAMPLE_LOG2:  os_reg = data[1:0];
            CSR_SYNC_WORD:        sync_reg = data[7:0];
            CSR_PREAMBLE_COUNT:   pre_reg = data[15:0];
            default: ;
         endcase
      endfunction

      function longint round_sat(longint v, longint amp);
         longint r;
         r = (v + CFM_ROUND_BIAS) >>> CFM_FRAC_SHIFT;
         if (r > amp) r = amp;
         if (r < -amp) r = -amp;
         return r;
      endfunction

      // quadrant from the top two bits, CORDIC on the 30-bit residual
      function void rotate(input logic [31:0] ang,
                           output logic signed [CFM_SAMPLE_BITS-1:0] c,
                           output logic signed [CFM_SAMPLE_BITS-1:0] s);
         longint amp, x, y, z, dx, dy, xr, yr, cv, sv;
         amp = (longint'(1) <<< (CFM_SAMPLE_BITS - 1)) - 1;
         x = (amp * CFM_GAIN_Q) >>> CFM_GAIN_SHIFT;
         y = 0;
         z = {34'd0, ang[29:0]};
         for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - arc_turns[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + arc_turns[i];
            end
         end
         xr = round_sat(x, amp);
         yr = round_sat(y, amp);
         case (ang[31:30])
            2'd0: begin cv = xr;  sv = yr;  end
            2'd1: begin cv = -yr; sv = xr;  end
            2'd2: begin cv = -xr; sv = -yr; end
            default: begin cv = yr; sv = -xr; end
         endcase
         c = cv[CFM_SAMPLE_BITS-1:0];
         s = sv[CFM_SAMPLE_BITS-1:0];
      endfunction

      function void note_input(bit kind, logic [CFM_SYMBOL_BITS-1:0] value);
         int unsigned sf, os, nl, len, k, v;
         int          sh;
         bit          down;
         sample_type  e;
         if (kind == WORD_LOAD) begin
            if (seg == CFM_SEG_IDLE && pay_cnt < CFM_PAYLOAD_DEPTH) begin
               store[pay_cnt] = value;
               pay_cnt++;
            end
            return;
         end
         sf = sf_reg;
         if (sf < CFM_SF_MIN) sf = CFM_SF_MIN;
         if (sf > CFM_SF_MAX) sf = CFM_SF_MAX;
         os = os_reg;
         nl = 1 << (sf + os);
         if (seg == CFM_SEG_IDLE) begin
            phase = '0;
            sym_cnt = 0;
            smp_cnt = 0;
            seg = (pre_reg > 0) ? CFM_SEG_PRE : CFM_SEG_SYNC;
         end
         rotate(phase, e.in_phase, e.quadrature);
         e.segment = seg[1:0] - 2'd1;
         e.frame_last = 1'b0;

         v = 0;
         down = 1'b0;
         case (seg)
            CFM_SEG_SYNC:
               v = (sym_cnt == 0) ? 32'(sync_reg[7:4]) << CFM_SYNC_BIN_SHIFT
                                  : 32'(sync_reg[3:0]) << CFM_SYNC_BIN_SHIFT;
            CFM_SEG_SFD: down = 1'b1;
            CFM_SEG_PAY: if (sym_cnt < pay_cnt) v = store[sym_cnt];
            default: ;
         endcase
         k = down ? (((v << os) - smp_cnt) & (nl - 1)) : (((v << os) + smp_cnt) & (nl - 1));
         sh = CFM_PHASE_BITS - int'(sf) - 2 * int'(os);
         phase = phase + (32'(k) << sh) - (32'(nl >> 1) << sh);

         len = (seg == CFM_SEG_SFD && sym_cnt == CFM_SFD_QUARTER_SYM) ? (nl >> 2) : nl;
         smp_cnt++;
         if (smp_cnt >= len) begin
            smp_cnt = 0;
            sym_cnt++;
            if (seg == CFM_SEG_PRE && sym_cnt >= pre_reg) begin
               seg = CFM_SEG_SYNC;
               sym_cnt = 0;
            end else if (seg == CFM_SEG_SYNC && sym_cnt >= CFM_SYNC_CHIRPS) begin
               seg = CFM_SEG_SFD;
               sym_cnt = 0;
            end else if (seg == CFM_SEG_SFD && sym_cnt >= CFM_SFD_CHIRPS) begin
               seg = CFM_SEG_PAY;
               sym_cnt = 0;
            end
            if (seg == CFM_SEG_PAY && sym_cnt >= pay_cnt) begin
               seg = CFM_SEG_IDLE;
               sym_cnt = 0;
               pay_cnt = 0;
               e.frame_last = 1'b1;
               frames_done++;
            end
         end
         sym_cnt = sym_cnt & 32'hFFFF;
         expected_samples.push_back(e);
      endfunction

      function void check_result(sample_type got);
         sample_type e;
         checked++;
         if (expected_samples.size() == 0) begin
            $error("sample word with none expected");
            errors++;
            return;
         end
         e = expected_samples.pop_front();
         if (got.in_phase !== e.in_phase) begin
            $error("in_phase expected %0d actual %0d", e.in_phase, got.in_phase);
            errors++;
         end
         if (got.quadrature !== e.quadrature) begin
            $error("quadrature expected %0d actual %0d", e.quadrature, got.quadrature);
            errors++;
         end
         if (got.segment !== e.segment) begin
            $error("segment expected %0d actual %0d", e.segment, got.segment);
            errors++;
         end
         if (got.frame_last !== e.frame_last) begin
            $error("frame_last expected %0d actual %0d", e.frame_last, got.frame_last);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   logic [1:0]               csr_index;
   logic [CFM_CSR_WIDTH-1:0] csr_wdata;
   bit                       no_idle;
   int                       words_sent;
   int                       stall_cycles;
   chirp_scoreboard          sb = new();

   cfm_req_if req_if ();
   cfm_rsp_if rsp_if ();

   chirp_frame_modulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin : monitor
      sample_type got;
      if (!reset) begin
         if (csr_we)
            sb.write_reg(csr_index, csr_wdata);
         if (req_if.valid && req_if.ready)
            sb.note_input(req_if.kind, req_if.symbol_value);
         if (rsp_if.valid && rsp_if.ready) begin
            got.in_phase = rsp_if.in_phase;
            got.quadrature = rsp_if.quadrature;
            got.segment = rsp_if.segment;
            got.frame_last = rsp_if.frame_last;
            sb.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles = 0;
      else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // sample sink: random stalls, plus one long hold-off so the input backs up
   initial begin
      bit held;
      held = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sb.checked >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else
            rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // all driver tasks start and end at a falling edge
   task automatic send_word(input bit kind, input logic [CFM_SYMBOL_BITS-1:0] value);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.symbol_value <= value;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic program_regs(input logic [CFM_CSR_WIDTH-1:0] sf_word,
                               input logic [CFM_CSR_WIDTH-1:0] os_word,
                               input logic [CFM_CSR_WIDTH-1:0] sync_word,
                               input logic [CFM_CSR_WIDTH-1:0] pre_word);
      logic [1:0]               idx [4];
      logic [CFM_CSR_WIDTH-1:0] val [4];
      idx = '{CSR_SPREADING_FACTOR, CSR_OVERSAMPLE_LOG2, CSR_SYNC_WORD, CSR_PREAMBLE_COUNT};
      val = '{sf_word, os_word, sync_word, pre_word};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // ticks until count is reached (0: no count) or the frame ends; stray loads mixed in
   task automatic run_ticks(input int count, input int noise_pct);
      int sent;
      int start_frames;
      sent = 0;
      start_frames = sb.frames_done;
      while (sb.frames_done == start_frames && (count == 0 || sent < count)) begin
         if (sent > 0 && $urandom_range(99) < noise_pct)
            send_word(WORD_LOAD, 12'($urandom));
         else begin
            send_word(WORD_TICK, 12'($urandom));
            sent++;
         end
      end
   endtask

   task automatic random_frame();
      logic [3:0] sf;
      logic [1:0] os;
      sf = ($urandom_range(7) == 0) ? 4'($urandom_range(6)) :
           ($urandom_range(7) == 0) ? 4'd8 : 4'd7;
      os = ($urandom_range(7) == 0) ? 2'd1 : 2'd0;
      program_regs(16'(sf), 16'(os), 16'($urandom_range(255)), 16'($urandom_range(3)));
      repeat ($urandom_range(6)) send_word(WORD_LOAD, 12'($urandom));
      if ($urandom_range(3) == 0) begin
         // settings changed part way through the frame
         run_ticks($urandom_range(1, 400), 3);
         pause_until_drained();
         program_regs(16'd7, 16'($urandom_range(1)), 16'($urandom_range(255)),
                      16'($urandom_range(2)));
      end
      run_ticks(0, 3);
      pause_until_drained();
   endtask

   initial begin
      int base;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind = WORD_LOAD;
      req_if.symbol_value = '0;
      csr_we = 1'b0;
      csr_index = CSR_SPREADING_FACTOR;
      csr_wdata = '0;
      no_idle = 1'b0;
      words_sent = 0;
      stall_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, payload at both extremes, loads during the frame are dropped
      send_word(WORD_LOAD, 12'h000);
      send_word(WORD_LOAD, 12'hFFF);
      run_ticks(0, 1);
      pause_until_drained();

      // spreading factor above range, widest oversampling, endless preamble
      program_regs(16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF);
      run_ticks(300, 0);
      pause_until_drained();
      // cut the preamble short; spreading factor below range; empty payload
      program_regs(16'hFFF0, 16'hFFFC, 16'hFF00, 16'd1);
      run_ticks(0, 0);
      pause_until_drained();

      // no preamble, oversampling by 8, one payload word
      program_regs(16'd7, 16'd3, 16'h000F, 16'd0);
      send_word(WORD_LOAD, 12'hFFF);
      run_ticks(0, 0);
      pause_until_drained();

      // overfill the store, then a long run with no stalls on either side
      program_regs(16'd7, 16'd0, 16'h00A5, 16'd0);
      repeat (CFM_PAYLOAD_DEPTH + 4) send_word(WORD_LOAD, 12'($urandom));
      no_idle = 1'b1;
      run_ticks(3000, 0);
      no_idle = 1'b0;
      run_ticks(0, 1);
      pause_until_drained();

      base = words_sent;
      while (words_sent - base < RANDOM_WORDS)
         random_frame();

      pause_until_drained();
      repeat (40) @(negedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
